FILE: hw/rtl/gpr_pkg.sv
// Shared types, constants and helpers of the Gaussian pyramid reduce block.
package gpr_pkg;

   // Geometry defaults; the top level may override them
   localparam int MAX_ROWS_DEF    = 512;
   localparam int MAX_COLS_DEF    = 512;
   localparam int KERNEL_TAPS     = 5;
   localparam int KERNEL_CENTER   = KERNEL_TAPS / 2;
   localparam int KIDX_W          = $clog2(KERNEL_TAPS);

   // Field widths
   localparam int COORD_W         = 9;
   localparam int PIX_W           = 16;
   localparam int SIZE_W          = 10;
   localparam int TAP_W           = 16;
   localparam int WPROD_W         = 2 * TAP_W;
   localparam int PROD_W          = PIX_W + WPROD_W;
   localparam int ACC_W           = PROD_W + $clog2(KERNEL_TAPS * KERNEL_TAPS);
   localparam int FRAC_SHIFT      = 32;

   // Configuration port
   localparam int CSR_DATA_W      = 32;
   localparam int CSR_ADDR_W      = 5;
   localparam int CSR_IDX_W       = CSR_ADDR_W - 2;

   // Register reset values
   localparam logic [SIZE_W-1:0] SOURCE_ROWS_RST = SIZE_W'(257);
   localparam logic [SIZE_W-1:0] SOURCE_COLS_RST = SIZE_W'(257);
   localparam logic [SIZE_W-1:0] DEST_ROWS_RST   = SIZE_W'(129);
   localparam logic [SIZE_W-1:0] DEST_COLS_RST   = SIZE_W'(129);
   localparam logic [TAP_W-1:0]  TAP_OUTER_RST   = TAP_W'(3277);
   localparam logic [TAP_W-1:0]  TAP_INNER_RST   = TAP_W'(16384);
   localparam logic [TAP_W-1:0]  TAP_MIDDLE_RST  = TAP_W'(26214);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SOURCE_ROWS = 3'd0,
      REG_SOURCE_COLS = 3'd1,
      REG_DEST_ROWS   = 3'd2,
      REG_DEST_COLS   = 3'd3,
      REG_TAP_OUTER   = 3'd4,
      REG_TAP_INNER   = 3'd5,
      REG_TAP_MIDDLE  = 3'd6
   } gpr_reg_type;

   typedef enum logic {
      OP_WRITE   = 1'b0,
      OP_COMPUTE = 1'b1
   } gpr_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } gpr_state_type;

   // Symmetric kernel weight for tap position k (0 .. KERNEL_TAPS-1)
   function automatic logic [TAP_W-1:0] tap_pick(
      input logic [KIDX_W-1:0] k,
      input logic [TAP_W-1:0]  t_outer,
      input logic [TAP_W-1:0]  t_inner,
      input logic [TAP_W-1:0]  t_middle
   );
      logic [TAP_W-1:0] w;
      if (k == KIDX_W'(KERNEL_CENTER)) begin
         w = t_middle;
      end else if (k == KIDX_W'(KERNEL_CENTER - 1) || k == KIDX_W'(KERNEL_CENTER + 1)) begin
         w = t_inner;
      end else begin
         w = t_outer;
      end
      return w;
   endfunction

endpackage

FILE: hw/rtl/gpr_ifs.sv
// Valid/ready channel interfaces for requests and responses.
interface gpr_req_if;
   import gpr_pkg::*;
   logic               valid;
   logic               ready;
   logic               operation;
   logic [COORD_W-1:0] row;
   logic [COORD_W-1:0] col;
   logic [PIX_W-1:0]   pixel_in;

   modport source (output valid, operation, row, col, pixel_in, input ready);
   modport sink   (input valid, operation, row, col, pixel_in, output ready);
endinterface

interface gpr_rsp_if;
   import gpr_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_out;
   logic             out_of_range;

   modport source (output valid, pixel_out, out_of_range, input ready);
   modport sink   (input valid, pixel_out, out_of_range, output ready);
endinterface

FILE: hw/rtl/gpr_image_ram.sv
// Source image memory: one write port, one read port, registered read data.
module gpr_image_ram #(
   parameter int ADDR_W = 18,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);
   localparam int DEPTH = 2 ** ADDR_W;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/gaussian_pyramid_reduce_top.sv
// Top level of the Gaussian pyramid reduce block: registers, sequencer, MAC pipeline.
//
// A write request stores one Q8.8 source pixel in the image memory when its row and
// column lie inside it. A compute request reads the 5x5 neighborhood of source pixel
// (2*row, 2*col) through the single read port of the image memory, one pixel per
// cycle, multiplies each by its separable weight and accumulates. After the 25 reads
// the last pixel passes the read, multiply and accumulate stages and is then rounded
// into the output register; the request side stays closed until that load, which
// comes later while the output register still holds an untaken response. A compute
// request outside the output size skips the reads and answers with out_of_range set.
// A finished response waits in the output register while the next request is already
// taken. Neighborhood indices outside the source image wrap once and are then clamped
// to the edge. The image memory has no reset; a read of a pixel never written returns
// an arbitrary value.
module gaussian_pyramid_reduce_top #(
   parameter int MAX_ROWS = gpr_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = gpr_pkg::MAX_COLS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   gpr_req_if.sink                         req_chan,
   gpr_rsp_if.source                       rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [gpr_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [gpr_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [gpr_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import gpr_pkg::*;

   localparam int RW   = $clog2(MAX_ROWS);
   localparam int CW   = $clog2(MAX_COLS);
   localparam int AW   = RW + CW;
   localparam int MAXN = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
   localparam int NB   = $clog2(MAXN + 1);
   localparam int IW   = ((NB > COORD_W + 1) ? NB : COORD_W + 1) + 2;
   localparam int QW   = ACC_W + 1 - FRAC_SHIFT;

   localparam logic signed [IW-1:0] ONE_S    = IW'(1);
   localparam logic signed [IW-1:0] CENTER_S = IW'(KERNEL_CENTER);
   localparam logic [ACC_W:0]       HALF_LSB = (ACC_W + 1)'(64'h8000_0000);

   // ---------------- configuration registers ----------------
   logic [SIZE_W-1:0] source_rows_ff, source_cols_ff, dest_rows_ff, dest_cols_ff;
   logic [TAP_W-1:0]  tap_outer_ff, tap_inner_ff, tap_middle_ff;
   logic              csr_wr;
   gpr_reg_type       csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = gpr_reg_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         source_rows_ff <= SOURCE_ROWS_RST;
         source_cols_ff <= SOURCE_COLS_RST;
         dest_rows_ff   <= DEST_ROWS_RST;
         dest_cols_ff   <= DEST_COLS_RST;
         tap_outer_ff   <= TAP_OUTER_RST;
         tap_inner_ff   <= TAP_INNER_RST;
         tap_middle_ff  <= TAP_MIDDLE_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_SOURCE_ROWS: source_rows_ff <= csr_pwdata[SIZE_W-1:0];
            REG_SOURCE_COLS: source_cols_ff <= csr_pwdata[SIZE_W-1:0];
            REG_DEST_ROWS:   dest_rows_ff   <= csr_pwdata[SIZE_W-1:0];
            REG_DEST_COLS:   dest_cols_ff   <= csr_pwdata[SIZE_W-1:0];
            REG_TAP_OUTER:   tap_outer_ff   <= csr_pwdata[TAP_W-1:0];
            REG_TAP_INNER:   tap_inner_ff   <= csr_pwdata[TAP_W-1:0];
            REG_TAP_MIDDLE:  tap_middle_ff  <= csr_pwdata[TAP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_SOURCE_ROWS: csr_prdata = CSR_DATA_W'(source_rows_ff);
         REG_SOURCE_COLS: csr_prdata = CSR_DATA_W'(source_cols_ff);
         REG_DEST_ROWS:   csr_prdata = CSR_DATA_W'(dest_rows_ff);
         REG_DEST_COLS:   csr_prdata = CSR_DATA_W'(dest_cols_ff);
         REG_TAP_OUTER:   csr_prdata = CSR_DATA_W'(tap_outer_ff);
         REG_TAP_INNER:   csr_prdata = CSR_DATA_W'(tap_inner_ff);
         REG_TAP_MIDDLE:  csr_prdata = CSR_DATA_W'(tap_middle_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // ---------------- sequencer state ----------------
   gpr_state_type      state_ff, state_in;
   logic [KIDX_W-1:0]  ky_ff, ky_in, kx_ff, kx_in;
   logic [COORD_W-1:0] row_ff, row_in, col_ff, col_in;
   logic               oor_ff, oor_in;
   logic               v1_ff, v1_in, v2_ff, v2_in;
   logic [WPROD_W-1:0] w_ff, w_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]   rsp_pixel_ff, rsp_pixel_in;
   logic               rsp_oor_ff, rsp_oor_in;

   logic               req_xfer, is_compute, req_oor, last_tap, issue, rsp_load;
   logic               wr_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [PIX_W-1:0]   rd_data;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_xfer       = req_chan.valid & req_chan.ready;
   assign is_compute     = (gpr_op_type'(req_chan.operation) == OP_COMPUTE);
   assign req_oor        = (SIZE_W'(req_chan.row) >= dest_rows_ff) ||
                           (SIZE_W'(req_chan.col) >= dest_cols_ff);
   assign last_tap       = (ky_ff == KIDX_W'(KERNEL_TAPS - 1)) &&
                           (kx_ff == KIDX_W'(KERNEL_TAPS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && is_compute) begin
               state_in = req_oor ? ST_FINISH : ST_RUN;
            end
         end
         ST_RUN: begin
            if (last_tap) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!v1_ff && !v2_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state-decoded controls
   always_comb begin
      issue    = 1'b0;
      rsp_load = 1'b0;
      wr_en    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            wr_en = req_xfer && !is_compute &&
                    (32'(req_chan.row) < MAX_ROWS) && (32'(req_chan.col) < MAX_COLS);
         end
         ST_RUN:    issue    = 1'b1;
         ST_DRAIN:  ;
         ST_FINISH: rsp_load = !rsp_valid_ff || rsp_chan.ready;
         default: ;
      endcase
   end

   assign wr_addr = {RW'(req_chan.row), CW'(req_chan.col)};

   // ---------------- neighborhood address ----------------
   logic [NB-1:0]        n_rows, n_cols;
   logic signed [IW-1:0] sr_s, sc_s, nr_s, nc_s;

   always_comb begin
      if (source_rows_ff == '0) begin
         n_rows = NB'(1);
      end else if (32'(source_rows_ff) > MAX_ROWS) begin
         n_rows = NB'(MAX_ROWS);
      end else begin
         n_rows = NB'(source_rows_ff);
      end
      if (source_cols_ff == '0) begin
         n_cols = NB'(1);
      end else if (32'(source_cols_ff) > MAX_COLS) begin
         n_cols = NB'(MAX_COLS);
      end else begin
         n_cols = NB'(source_cols_ff);
      end
   end

   always_comb begin
      nr_s = $signed(IW'(n_rows));
      nc_s = $signed(IW'(n_cols));
      sr_s = $signed(IW'({row_ff, 1'b0}) + IW'(ky_ff)) - CENTER_S;
      sc_s = $signed(IW'({col_ff, 1'b0}) + IW'(kx_ff)) - CENTER_S;
      // wrap once, then clamp to the edge
      if (sr_s < 0) begin
         sr_s = sr_s + nr_s;
      end else if (sr_s >= nr_s) begin
         sr_s = sr_s - nr_s;
      end
      if (sr_s < 0) begin
         sr_s = '0;
      end else if (sr_s >= nr_s) begin
         sr_s = nr_s - ONE_S;
      end
      if (sc_s < 0) begin
         sc_s = sc_s + nc_s;
      end else if (sc_s >= nc_s) begin
         sc_s = sc_s - nc_s;
      end
      if (sc_s < 0) begin
         sc_s = '0;
      end else if (sc_s >= nc_s) begin
         sc_s = nc_s - ONE_S;
      end
   end

   assign rd_addr = {sr_s[RW-1:0], sc_s[CW-1:0]};

   gpr_image_ram #(
      .ADDR_W (AW),
      .DATA_W (PIX_W)
   ) u_image_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_chan.pixel_in),
      .rd_en   (issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ---------------- datapath ----------------
   logic [ACC_W:0]   rnd_sum;
   logic [QW-1:0]    rnd_q;

   assign rnd_sum = {1'b0, acc_ff} + HALF_LSB;
   assign rnd_q   = rnd_sum[ACC_W:FRAC_SHIFT];

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      oor_in = oor_ff;
      ky_in  = ky_ff;
      kx_in  = kx_ff;
      if (req_xfer) begin
         row_in = req_chan.row;
         col_in = req_chan.col;
         oor_in = req_oor;
         ky_in  = '0;
         kx_in  = '0;
      end else if (issue) begin
         if (kx_ff == KIDX_W'(KERNEL_TAPS - 1)) begin
            kx_in = '0;
            ky_in = ky_ff + KIDX_W'(1);
         end else begin
            kx_in = kx_ff + KIDX_W'(1);
         end
      end

      // weight product travels alongside the memory read
      w_in    = tap_pick(ky_ff, tap_outer_ff, tap_inner_ff, tap_middle_ff) *
                tap_pick(kx_ff, tap_outer_ff, tap_inner_ff, tap_middle_ff);
      v1_in   = issue;
      prod_in = rd_data * w_ff;
      v2_in   = v1_ff;

      acc_in = acc_ff;
      if (req_xfer) begin
         acc_in = '0;
      end else if (v2_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_oor_in   = rsp_oor_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_oor_in   = oor_ff;
         if (oor_ff) begin
            rsp_pixel_in = '0;
         end else if (|rnd_q[QW-1:PIX_W]) begin
            rsp_pixel_in = '1;
         end else begin
            rsp_pixel_in = rnd_q[PIX_W-1:0];
         end
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ky_ff        <= ky_in;
      kx_ff        <= kx_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      oor_ff       <= oor_in;
      w_ff         <= w_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_oor_ff   <= rsp_oor_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.pixel_out    = rsp_pixel_ff;
   assign rsp_chan.out_of_range = rsp_oor_ff;

endmodule

FILE: hw/rtl/gpr_checker.sv
// Port-level checks of the Gaussian pyramid reduce top level, bound to it.
module gpr_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     req_operation,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [gpr_pkg::PIX_W-1:0] rsp_pixel_out,
   input logic                     rsp_out_of_range
);
   import gpr_pkg::*;

   // a held response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_pixel_out) && $stable(rsp_out_of_range))
      else $error("response changed while stalled");

   // one compute at a time: intake closes after a compute transfer
   a_compute_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_operation == OP_COMPUTE) |=> !req_ready)
      else $error("request taken while a compute is in flight");

   // flagged responses carry a zero pixel
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> (rsp_pixel_out == '0))
      else $error("out-of-range response with nonzero pixel");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind gaussian_pyramid_reduce_top gpr_checker u_gpr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_operation    (req_chan.operation),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_pixel_out    (rsp_chan.pixel_out),
   .rsp_out_of_range (rsp_chan.out_of_range)
);
